/* rtl/core/gvst_pkg.sv */
// Shared types, codes and reset values for the growable vector core.
package gvst_pkg;

   localparam int CFG_W      = 11;
   localparam int FACTOR_W   = 4;
   localparam int IDX_W      = 10;
   localparam int VALUE_W    = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_POP    = 2'd1,
      REQ_READ   = 2'd2,
      REQ_WRITE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_WRONG_DATA    = 3'd1,
      ST_OVERFLOW      = 3'd2,
      ST_ALLOC_FAIL    = 3'd3,
      ST_UNDERFLOW     = 3'd4,
      ST_OUT_OF_BOUNDS = 3'd5
   } status_type;

   // Register indexes, taken from paddr[3:2]
   localparam logic [1:0] CSR_INIT_CAP   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_SIZE = 2'd1;
   localparam logic [1:0] CSR_SHRINK     = 2'd2;

   localparam logic [CFG_W-1:0]    INIT_CAP_RST   = 11'd16;
   localparam logic [CFG_W-1:0]    BLOCK_SIZE_RST = 11'd16;
   localparam logic [FACTOR_W-1:0] SHRINK_RST     = 4'd2;

   typedef struct packed {
      logic [CFG_W-1:0]    initial_capacity;
      logic [CFG_W-1:0]    block_size;
      logic [FACTOR_W-1:0] shrink_factor;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic       rd_sel;
   } meta_type;

endpackage

/* rtl/core/gvst_mem.sv */
// Single-port item memory with registered read data.
module gvst_mem #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 10
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic                  we,
   input  logic [AW-1:0]         addr,
   input  logic [DATA_WIDTH-1:0] wdata,
   output logic [DATA_WIDTH-1:0] rdata
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            store_ff[addr] <= wdata;
         end else begin
            rdata_ff <= store_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/gvst_csr.sv */
// Configuration register file behind the APB-style port.
module gvst_csr import gvst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            CSR_INIT_CAP:   cfg_in.initial_capacity = pwdata[CFG_W-1:0];
            CSR_BLOCK_SIZE: cfg_in.block_size       = pwdata[CFG_W-1:0];
            CSR_SHRINK:     cfg_in.shrink_factor    = pwdata[FACTOR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_capacity <= INIT_CAP_RST;
         cfg_ff.block_size       <= BLOCK_SIZE_RST;
         cfg_ff.shrink_factor    <= SHRINK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         CSR_INIT_CAP:   prdata = CSR_DATA_W'(cfg_ff.initial_capacity);
         CSR_BLOCK_SIZE: prdata = CSR_DATA_W'(cfg_ff.block_size);
         CSR_SHRINK:     prdata = CSR_DATA_W'(cfg_ff.shrink_factor);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/gvst_ctrl.sv */
// Request decode, count and capacity registers, memory command generation.
module gvst_ctrl import gvst_pkg::*; #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 11,
   parameter int AW         = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cfg_type               cfg,
   input  logic [1:0]            req_kind,
   input  logic [IDX_W-1:0]      index,
   input  logic [DATA_WIDTH-1:0] val,
   output logic                  mem_en,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_addr,
   output meta_type              meta,
   output logic [CNT_W-1:0]      count_next,
   output logic [CNT_W-1:0]      cap_next
);

   localparam int SUM_W  = CNT_W + 1;
   localparam int PROD_W = FACTOR_W + CFG_W;
   localparam int CMP_W  = (CNT_W > PROD_W) ? CNT_W : PROD_W;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [CNT_W-1:0]    blk, init_cap, slack, idx_ext, count_dec;
   logic [SUM_W-1:0]    grown;
   logic [FACTOR_W-1:0] factor;
   logic [PROD_W-1:0]   prod;
   logic                full, val_zero, op_rd, op_wr;

   always_comb begin
      blk       = CNT_W'(cfg.block_size);
      init_cap  = CNT_W'(cfg.initial_capacity);
      full      = count_ff >= cap_ff;
      grown     = {1'b0, cap_ff} + {1'b0, blk};
      factor    = (cfg.shrink_factor == '0) ? FACTOR_W'(1) : cfg.shrink_factor;
      prod      = PROD_W'(factor) * PROD_W'(cfg.block_size);
      slack     = (cap_ff >= count_ff) ? cap_ff - count_ff : '0;
      idx_ext   = CNT_W'(index);
      count_dec = count_ff - CNT_W'(1);
      val_zero  = (val == '0);

      meta.status = ST_OK;
      meta.rd_sel = 1'b0;
      op_rd       = 1'b0;
      op_wr       = 1'b0;
      mem_addr    = count_ff[AW-1:0];
      count_in    = count_ff;
      cap_in      = cap_ff;

      case (req_kind_type'(req_kind))
         REQ_APPEND: begin
            if (val_zero) begin
               meta.status = ST_WRONG_DATA;
            end else if (full && blk == '0) begin
               meta.status = ST_OVERFLOW;
            end else if (full && grown > SUM_W'(DEPTH)) begin
               meta.status = ST_ALLOC_FAIL;
            end else if (count_ff >= CNT_W'(DEPTH)) begin
               meta.status = ST_ALLOC_FAIL;
            end else begin
               if (full) begin
                  cap_in = grown[CNT_W-1:0];
               end
               op_wr    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_POP: begin
            mem_addr = count_dec[AW-1:0];
            if (count_ff == '0) begin
               meta.status = ST_UNDERFLOW;
            end else begin
               // shrink test sees the count before the removal
               if (init_cap < cap_ff && CMP_W'(slack) >= CMP_W'(prod)) begin
                  cap_in = cap_ff - blk;
               end
               op_rd       = 1'b1;
               meta.rd_sel = 1'b1;
               count_in    = count_dec;
            end
         end
         REQ_READ: begin
            mem_addr = idx_ext[AW-1:0];
            if (idx_ext >= count_ff) begin
               meta.status = ST_OUT_OF_BOUNDS;
            end else begin
               op_rd       = 1'b1;
               meta.rd_sel = 1'b1;
            end
         end
         REQ_WRITE: begin
            mem_addr = idx_ext[AW-1:0];
            if (val_zero) begin
               meta.status = ST_WRONG_DATA;
            end else if (idx_ext >= count_ff) begin
               meta.status = ST_OUT_OF_BOUNDS;
            end else begin
               op_wr = 1'b1;
            end
         end
         default: meta.status = ST_OK;
      endcase

      mem_en = accept && (op_rd || op_wr);
      mem_we = op_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CNT_W'(INIT_CAP_RST);
      end else if (accept) begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   assign count_next = count_in;
   assign cap_next   = cap_in;

endmodule

/* rtl/core/growable_vector_stack_table_core.sv */
// Top level of the growable vector core: request decode, item memory, result stage.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_type, req_index, req_value
//   rsp_      out        rsp_valid/rsp_ready    rsp_status, rsp_read_value,
//                                               rsp_item_count_out, rsp_capacity_out
//   csr       in/out     psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// Each transaction is decoded and issues its memory access as it is accepted, and its
// decode results wait in the pending stage until they move into the result register.
// Count and capacity update at the accept edge, so a new transaction is taken every
// cycle while results drain; the single memory port sets that one-per-cycle figure.
// Reset clears count to zero and sets capacity and registers to their defaults; the
// item memory is not cleared, since only entries below the count are ever read.
// A stalled result holds the pending stage, and req_ready drops until it moves.
module growable_vector_stack_table_core import gvst_pkg::*; #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [IDX_W-1:0]      req_index,
   input  logic [VALUE_W-1:0]    req_value,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [VALUE_W-1:0]    rsp_read_value,
   output logic [CFG_W-1:0]      rsp_item_count_out,
   output logic [CFG_W-1:0]      rsp_capacity_out,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW        = $clog2(DEPTH);
   localparam int CNT_W_RAW = $clog2(DEPTH + 1);
   // counts must also hold any capacity the registers can set
   localparam int CNT_W     = (CNT_W_RAW > CFG_W) ? CNT_W_RAW : CFG_W;

   cfg_type               cfg;
   logic                  accept;
   logic                  mem_en, mem_we;
   logic [AW-1:0]         mem_addr;
   logic [DATA_WIDTH-1:0] val, mem_rdata;
   logic [63:0]           value_ext, rdata_ext;
   meta_type              meta;
   logic [CNT_W-1:0]      count_next, cap_next;

   // pending stage: waits for memory read data
   logic                  pend_ff, pend_in;
   meta_type              pend_meta_ff;
   logic [CFG_W-1:0]      pend_count_ff, pend_cap_ff;
   logic                  out_load;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_data_ff;
   logic [CFG_W-1:0]      rsp_count_ff, rsp_cap_ff;

   // mask the incoming data to the stored width
   assign value_ext = {32'b0, req_value};
   assign val       = value_ext[DATA_WIDTH-1:0];

   gvst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gvst_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .AW         (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cfg        (cfg),
      .req_kind   (req_type),
      .index      (req_index),
      .val        (val),
      .mem_en     (mem_en),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .meta       (meta),
      .count_next (count_next),
      .cap_next   (cap_next)
   );

   gvst_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (val),
      .rdata (mem_rdata)
   );

   // Move the pending transaction into the result register when that register
   // is empty or being drained. Read data stays stable while pending, since a
   // new read only issues on the edge that empties this stage.
   assign out_load  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || out_load;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (out_load) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture decode results at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_meta_ff  <= meta;
         pend_count_ff <= count_next[CFG_W-1:0];
         pend_cap_ff   <= cap_next[CFG_W-1:0];
      end
   end

   // read data only for successful pops and reads, zero otherwise
   assign rdata_ext = 64'(mem_rdata);

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= pend_meta_ff.status;
         rsp_data_ff   <= pend_meta_ff.rd_sel ? rdata_ext[VALUE_W-1:0] : '0;
         rsp_count_ff  <= pend_count_ff;
         rsp_cap_ff    <= pend_cap_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_data_ff;
   assign rsp_item_count_out = rsp_count_ff;
   assign rsp_capacity_out   = rsp_cap_ff;

endmodule

/* rtl/core/gvst_checker.sv */
// Port-level checker for the growable vector core and its bind.
module gvst_checker import gvst_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_status,
   input logic [VALUE_W-1:0]  rsp_read_value,
   input logic [CFG_W-1:0]    rsp_item_count_out,
   input logic [CFG_W-1:0]    rsp_capacity_out
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_item_count_out))
      else $error("result changed while stalled");

   // failed transactions return no data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("data returned on a failed transaction");

   // underflow only on an empty vector
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNDERFLOW |-> rsp_item_count_out == '0)
      else $error("underflow with items stored");

   // overflow only on a full vector
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERFLOW |-> rsp_item_count_out >= rsp_capacity_out)
      else $error("overflow on a vector that is not full");

endmodule

bind growable_vector_stack_table_core gvst_checker u_gvst_checker (.*);
